@@ hdl/xoshiro256_jump_engine_assert.svh @@
// Assertion macros for the xoshiro256 jump engine.
// Needs a clock named clock and a reset named reset in the including scope.
`ifndef XOSHIRO256_JUMP_ENGINE_ASSERT_SVH
`define XOSHIRO256_JUMP_ENGINE_ASSERT_SVH

// same-cycle implication
`define XJE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("xjump: assertion failed");

// next-cycle implication
`define XJE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("xjump: assertion failed");

`endif

@@ hdl/xjump_pkg.sv @@
// Shared types, constants and the xoshiro256 state transition for the jump engine.
// No dependencies.
package xjump_pkg;

   localparam int WORD_W    = 64;
   localparam int HALF_W    = WORD_W / 2;
   localparam int NUM_WORDS = 4;
   localparam int IDX_W     = 2;
   localparam int POLY_W    = WORD_W * NUM_WORDS;
   localparam int CNT_W     = 8;
   localparam int REQ_W     = 72;
   localparam int RSP_W     = 72;

   localparam logic [1:0] FUNC_SEED  = 2'd0;
   localparam logic [1:0] FUNC_SHORT = 2'd1;
   localparam logic [1:0] FUNC_LONG  = 2'd2;

   localparam logic [IDX_W-1:0] LAST_POS = 2'd3;

   localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [WORD_W-1:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
   localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94d049bb133111eb;

   localparam logic [POLY_W-1:0] JUMP_SHORT = {
      64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
      64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba};
   localparam logic [POLY_W-1:0] JUMP_LONG = {
      64'h39109bb02acbe635, 64'h77710069854ee241,
      64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf};

   typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] value;
   } mix_out_type;

   typedef struct packed {
      logic              start;
      logic              long_sel;
      logic              seed_wr;
      logic [IDX_W-1:0]  seed_index;
      logic [WORD_W-1:0] seed_value;
   } jump_ctrl_type;

   function automatic state_type xoshiro_advance(input state_type s);
      state_type         r;
      logic [WORD_W-1:0] t;
      r = s;
      t = r[1] << 17;
      r[2] = r[2] ^ r[0];
      r[3] = r[3] ^ r[1];
      r[1] = r[1] ^ r[2];
      r[0] = r[0] ^ r[3];
      r[2] = r[2] ^ t;
      r[3] = {r[3][18:0], r[3][63:19]};
      return r;
   endfunction

endpackage

@@ hdl/xoshiro256_jump_engine.sv @@
// xoshiro256 jump engine. A seed item (tuser 0) runs through the SplitMix64 mixer, whose two
// 64-bit multiplies each run as three passes through one 32x32 multiplier, and the mixed word
// is then stored. A take item (tuser 1 or 2) returns the four state words, one per cycle at
// best, the last with tlast, then jumps the state by 2^128 or 2^192 steps, one generator
// advance per cycle. No item is accepted until a seed or take is done; tuser 3 is dropped.
// Depends on xjump_pkg, xjump_mix, xjump_jump and xoshiro256_jump_engine_assert.svh.
`include "xoshiro256_jump_engine_assert.svh"

module xoshiro256_jump_engine
   import xjump_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // word_index[1:0], seed_bits[65:2], zero pad
   input  logic [1:0]       req_tuser,   // func[1:0]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // state_word[63:0], word_position[65:64], zero pad
   output logic             rsp_tlast
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MIX  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [1:0] ST_JUMP = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic             long_ff, long_in;
   logic             valid_ff, valid_in;
   logic             req_fire, rsp_fire;
   logic             mix_start;
   mix_out_type      mix_out;
   jump_ctrl_type    jump_ctrl;
   state_type        gen_state;
   logic             jump_done;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = valid_ff && rsp_tready;
   assign mix_start  = req_fire && (req_tuser == FUNC_SEED);

   xjump_mix u_mix (
      .clock   (clock),
      .reset   (reset),
      .start   (mix_start),
      .seed    (req_tdata[WORD_W+IDX_W-1:IDX_W]),
      .mix_out (mix_out)
   );

   assign jump_ctrl.start      = (state_ff == ST_EMIT) && rsp_fire && (pos_ff == LAST_POS);
   assign jump_ctrl.long_sel   = long_ff;
   assign jump_ctrl.seed_wr    = mix_out.done;
   assign jump_ctrl.seed_index = index_ff;
   assign jump_ctrl.seed_value = mix_out.value;

   xjump_jump u_jump (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (jump_ctrl),
      .gen_state (gen_state),
      .done      (jump_done)
   );

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      index_in = index_ff;
      long_in  = long_ff;
      valid_in = valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  FUNC_SEED: begin
                     index_in = req_tdata[IDX_W-1:0];
                     state_in = ST_MIX;
                  end
                  FUNC_SHORT, FUNC_LONG: begin
                     long_in  = (req_tuser == FUNC_LONG);
                     pos_in   = '0;
                     valid_in = 1'b1;
                     state_in = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MIX: begin
            if (mix_out.done) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (pos_ff == LAST_POS) begin
                  valid_in = 1'b0;
                  state_in = ST_JUMP;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_JUMP: begin
            if (jump_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
      index_ff <= index_in;
      long_ff  <= long_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_W-WORD_W-IDX_W){1'b0}}, pos_ff, gen_state[pos_ff]};
   assign rsp_tlast  = (pos_ff == LAST_POS);

   `XJE_ASSERT_NOW(a_busy_while_emit, rsp_tvalid, !req_tready)
   `XJE_ASSERT_NEXT(a_seed_no_output, req_tvalid && req_tready && req_tuser == FUNC_SEED, !rsp_tvalid)
   `XJE_ASSERT_NEXT(a_last_ends_take, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid && !req_tready)
   `XJE_ASSERT_NOW(a_jump_silent, state_ff == ST_JUMP, !rsp_tvalid)

endmodule

@@ hdl/xjump_mix.sv @@
// SplitMix64 seed mixer on one shared 32x32 multiplier, three partial products per multiply.
// Depends on xjump_pkg.
module xjump_mix
   import xjump_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] seed,
   output mix_out_type       mix_out
);

   localparam logic [2:0] PH_LL   = 3'd0;
   localparam logic [2:0] PH_LH   = 3'd1;
   localparam logic [2:0] PH_HL   = 3'd2;
   localparam logic [2:0] PH_ADD  = 3'd3;
   localparam logic [2:0] PH_FOLD = 3'd4;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              round_ff, round_in;
   logic [2:0]        phase_ff, phase_in;
   logic [WORD_W-1:0] z_ff, z_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] mp_ff, mp_in;
   logic [WORD_W-1:0] mul_const;
   logic [WORD_W-1:0] pre;
   logic [HALF_W-1:0] op_a, op_b;
   logic [WORD_W-1:0] prod;

   assign mul_const = round_ff ? SM_MUL2 : SM_MUL1;
   assign pre       = seed + SM_GAMMA;
   assign prod      = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};

   always_comb begin
      case (phase_ff)
         PH_LL: begin
            op_a = z_ff[HALF_W-1:0];
            op_b = mul_const[HALF_W-1:0];
         end
         PH_LH: begin
            op_a = z_ff[HALF_W-1:0];
            op_b = mul_const[WORD_W-1:HALF_W];
         end
         PH_HL: begin
            op_a = z_ff[WORD_W-1:HALF_W];
            op_b = mul_const[HALF_W-1:0];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      round_in = round_ff;
      phase_in = phase_ff;
      z_in     = z_ff;
      acc_in   = acc_ff;
      mp_in    = mp_ff;
      if (!busy_ff) begin
         if (start) begin
            z_in     = pre ^ (pre >> 30);
            phase_in = PH_LL;
            round_in = 1'b0;
            busy_in  = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_LL: begin
               mp_in    = prod;
               phase_in = PH_LH;
            end
            PH_LH: begin
               mp_in    = prod;
               acc_in   = mp_ff;
               phase_in = PH_HL;
            end
            PH_HL: begin
               mp_in    = prod;
               acc_in   = acc_ff + {mp_ff[HALF_W-1:0], {HALF_W{1'b0}}};
               phase_in = PH_ADD;
            end
            PH_ADD: begin
               acc_in   = acc_ff + {mp_ff[HALF_W-1:0], {HALF_W{1'b0}}};
               phase_in = PH_FOLD;
            end
            PH_FOLD: begin
               phase_in = PH_LL;
               if (!round_ff) begin
                  z_in     = acc_ff ^ (acc_ff >> 27);
                  round_in = 1'b1;
               end else begin
                  z_in    = acc_ff ^ (acc_ff >> 31);
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            default: begin
               phase_in = PH_LL;
               busy_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= 1'b0;
         phase_ff <= PH_LL;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         round_ff <= round_in;
         phase_ff <= phase_in;
      end
      z_ff   <= z_in;
      acc_ff <= acc_in;
      mp_ff  <= mp_in;
   end

   assign mix_out.done  = done_ff;
   assign mix_out.value = z_ff;

endmodule

@@ hdl/xjump_jump.sv @@
// Generator state and jump unit: one xoshiro256 advance and conditional accumulate per cycle.
// Depends on xjump_pkg.
module xjump_jump
   import xjump_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  jump_ctrl_type ctrl,
   output state_type     gen_state,
   output logic          done
);

   state_type         gen_state_ff, gen_state_in;
   state_type         acc_ff, acc_in;
   state_type         acc_next;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              long_ff, long_in;
   logic              done_ff, done_in;
   logic              poly_bit;

   assign poly_bit = long_ff ? JUMP_LONG[cnt_ff] : JUMP_SHORT[cnt_ff];
   assign acc_next = poly_bit ? (acc_ff ^ gen_state_ff) : acc_ff;

   always_comb begin
      gen_state_in = gen_state_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      busy_in      = busy_ff;
      long_in      = long_ff;
      done_in      = 1'b0;
      if (ctrl.start) begin
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         long_in = ctrl.long_sel;
      end else if (busy_ff) begin
         if (&cnt_ff) begin
            gen_state_in = acc_next;
            busy_in      = 1'b0;
            done_in      = 1'b1;
         end else begin
            gen_state_in = xoshiro_advance(gen_state_ff);
            acc_in       = acc_next;
            cnt_in       = cnt_ff + 1'b1;
         end
      end else if (ctrl.seed_wr) begin
         gen_state_in[ctrl.seed_index] = ctrl.seed_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_state_ff <= '0;
         busy_ff      <= 1'b0;
         done_ff      <= 1'b0;
         cnt_ff       <= '0;
         long_ff      <= 1'b0;
      end else begin
         gen_state_ff <= gen_state_in;
         busy_ff      <= busy_in;
         done_ff      <= done_in;
         cnt_ff       <= cnt_in;
         long_ff      <= long_in;
      end
      acc_ff <= acc_in;
   end

   assign gen_state = gen_state_ff;
   assign done      = done_ff;

endmodule

@@ test/xjump_checker.sv @@
// Checker for the xoshiro256 jump engine: watches both stream channels, tracks the generator
// state from accepted items and compares every returned state word. Depends on xjump_pkg.
module xjump_checker
   import xjump_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,    // word_index[1:0], seed_bits[65:2], zero pad
   input  logic [1:0]       req_tuser,    // func[1:0]
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,    // state_word[63:0], word_position[65:64], zero pad
   input  logic             rsp_tlast,
   output int               fail_count,
   output int               words_waiting,
   output int               seeds_seen,
   output int               takes_seen,
   output int               dropped_seen,
   output int               words_checked
);

   typedef struct {
      logic [WORD_W-1:0] word;
      logic [IDX_W-1:0]  position;
      logic              last;
   } state_word_type;

   state_word_type awaited_words[$];
   state_type      tracked_state;
   state_word_type got;
   state_word_type want;
   int             fails;
   int             seeds;
   int             takes;
   int             dropped;
   int             checked;

   function automatic logic [WORD_W-1:0] splitmix64(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] z;
      z = v + SM_GAMMA;
      z = (z ^ (z >> 30)) * SM_MUL1;
      z = (z ^ (z >> 27)) * SM_MUL2;
      return z ^ (z >> 31);
   endfunction

   function automatic state_type advance_state(input state_type s);
      state_type         n;
      logic [WORD_W-1:0] shifted;
      shifted = s[1] << 17;
      n[2] = s[2] ^ s[0];
      n[3] = s[3] ^ s[1];
      n[1] = s[1] ^ n[2];
      n[0] = s[0] ^ n[3];
      n[2] = n[2] ^ shifted;
      n[3] = (n[3] << 45) | (n[3] >> 19);
      return n;
   endfunction

   function automatic state_type jump_state(input state_type s, input logic [POLY_W-1:0] poly);
      state_type sum;
      sum = '0;
      for (int i = 0; i < POLY_W; i++) begin
         if (poly[i]) sum = sum ^ s;
         s = advance_state(s);
      end
      return sum;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         tracked_state = '0;
         awaited_words.delete();
         fails   = 0;
         seeds   = 0;
         takes   = 0;
         dropped = 0;
         checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.word     = rsp_tdata[WORD_W-1:0];
            got.position = rsp_tdata[WORD_W+IDX_W-1:WORD_W];
            got.last     = rsp_tlast;
            checked++;
            if (awaited_words.size() == 0) begin
               $error("state_word: expected none, got %h", got.word);
               fails++;
            end else begin
               want = awaited_words.pop_front();
               if (got.word !== want.word) begin
                  $error("state_word: expected %h, got %h", want.word, got.word);
                  fails++;
               end
               if (got.position !== want.position) begin
                  $error("word_position: expected %0d, got %0d", want.position, got.position);
                  fails++;
               end
               if (got.last !== want.last) begin
                  $error("last_word: expected %0b, got %0b", want.last, got.last);
                  fails++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               FUNC_SEED: begin
                  tracked_state[req_tdata[IDX_W-1:0]] =
                     splitmix64(req_tdata[IDX_W+WORD_W-1:IDX_W]);
                  seeds++;
               end
               FUNC_SHORT, FUNC_LONG: begin
                  for (int k = 0; k < NUM_WORDS; k++) begin
                     want.word     = tracked_state[k];
                     want.position = IDX_W'(k);
                     want.last     = (IDX_W'(k) == LAST_POS);
                     awaited_words.push_back(want);
                  end
                  tracked_state = jump_state(tracked_state,
                                             req_tuser == FUNC_SHORT ? JUMP_SHORT : JUMP_LONG);
                  takes++;
               end
               default: begin
                  dropped++;
               end
            endcase
         end
      end
      fail_count    <= fails;
      words_waiting <= awaited_words.size();
      seeds_seen    <= seeds;
      takes_seen    <= takes;
      dropped_seen  <= dropped;
      words_checked <= checked;
   end

endmodule

@@ test/testbench.sv @@
// Top of the xoshiro256 jump engine test: clock, reset, seed and take stimulus, result stalls
// and the verdict. Depends on xjump_pkg, xoshiro256_jump_engine and xjump_checker.
module testbench;
   import xjump_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int MAX_GAP      = 14;
   localparam int RANDOM_ITEMS = 480;
   localparam int LONG_HOLD    = 1500;
   localparam int DRAIN_CYCLES = 300;
   localparam int CYCLE_LIMIT  = 1_000_000;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic [1:0]       req_tuser  = FUNC_SEED;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;
   logic             steady       = 1'b0;
   logic             hold_request = 1'b0;
   int               cycle_count  = 0;
   int               items_sent   = 0;
   int               fail_count;
   int               words_waiting;
   int               seeds_seen;
   int               takes_seen;
   int               dropped_seen;
   int               words_checked;

   xoshiro256_jump_engine uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   xjump_checker tracker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .words_waiting (words_waiting),
      .seeds_seen    (seeds_seen),
      .takes_seen    (takes_seen),
      .dropped_seen  (dropped_seen),
      .words_checked (words_checked)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("xoshiro256_jump_engine: mismatch");
         $finish;
      end
   end

   function automatic logic [WORD_W-1:0] seed_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_item(input logic [1:0] func, input logic [IDX_W-1:0] index,
                            input logic [WORD_W-1:0] bits);
      int gap;
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {{(REQ_W - WORD_W - IDX_W){1'b0}}, bits, index};
      do @(posedge clock); while (!req_tready);
      if (func != FUNC_UNUSED) items_sent++;
   endtask

   initial begin : receiver
      int gap;
      bit held;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      int start;
      int pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // unseeded state, dropped code, extreme seeds on every word
      send_item(FUNC_SHORT, 2'd0, '0);
      send_item(FUNC_LONG, 2'd3, '1);
      send_item(FUNC_UNUSED, 2'd3, '1);
      send_item(FUNC_SEED, 2'd0, '0);
      send_item(FUNC_SEED, 2'd1, '1);
      send_item(FUNC_SEED, 2'd2, 64'h8000_0000_0000_0000);
      send_item(FUNC_SEED, 2'd3, 64'h0000_0000_0000_0001);
      send_item(FUNC_SHORT, 2'd2, 64'h5555_5555_5555_5555);
      send_item(FUNC_LONG, 2'd1, 64'haaaa_aaaa_aaaa_aaaa);
      send_item(FUNC_UNUSED, 2'd0, 64'h0123_4567_89ab_cdef);
      send_item(FUNC_SHORT, 2'd3, '1);
      send_item(FUNC_SEED, 2'd3, 64'h5555_5555_5555_5555);
      send_item(FUNC_SEED, 2'd2, 64'haaaa_aaaa_aaaa_aaaa);
      send_item(FUNC_LONG, 2'd0, '0);
      send_item(FUNC_SEED, 2'd0, '1);
      send_item(FUNC_SEED, 2'd1, '0);
      send_item(FUNC_SHORT, 2'd1, '1);
      send_item(FUNC_LONG, 2'd2, '0);

      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 24) == 0) steady <= ~steady;
         if (!hold_request && items_sent - start >= RANDOM_ITEMS / 3) begin
            // stall the result side while takes keep arriving
            hold_request <= 1'b1;
            repeat (5) send_item($urandom_range(0, 1) ? FUNC_LONG : FUNC_SHORT,
                                 2'($urandom_range(0, 3)), {$urandom, $urandom});
         end
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            repeat ($urandom_range(1, 4))
               send_item(FUNC_SEED, 2'($urandom_range(0, 3)), seed_value());
            repeat ($urandom_range(1, 3))
               send_item($urandom_range(0, 1) ? FUNC_LONG : FUNC_SHORT,
                         2'($urandom_range(0, 3)), {$urandom, $urandom});
         end else if (pick < 18) begin
            send_item(2'($urandom_range(0, 2)), 2'($urandom_range(0, 3)), seed_value());
         end else begin
            send_item(FUNC_UNUSED, 2'($urandom_range(0, 3)), {$urandom, $urandom});
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (words_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d seed writes, %0d takes and %0d dropped items,",
               seeds_seen, takes_seen, dropped_seen);
      $display("with %0d state words compared under random gaps and one long result stall.",
               words_checked);
      if (fail_count == 0 && words_waiting == 0) begin
         $display("xoshiro256_jump_engine: match");
      end else begin
         $display("xoshiro256_jump_engine: mismatch");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/xjump_pkg.sv
hdl/xjump_mix.sv
hdl/xjump_jump.sv
hdl/xoshiro256_jump_engine.sv
test/xjump_checker.sv
test/testbench.sv
